>>> src/bpra_pkg.sv
`timescale 1ns / 1ps

package bpra_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned PAGES_W  = 13;
  localparam int unsigned STATUS_W = 2;

  // Bitmap words are 32 pages wide.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned LANE_W    = 5;
  localparam int unsigned RUN_W     = 6;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL0_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL1_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL0_PAGES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL1_PAGES = 2'd3;

  // Controller states.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_FCHK  = 6'b000100,
    S_FRNG  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_APPLY = 6'b100000
  } state_e;

endpackage

>>> src/bitmap_page_run_allocator.sv
`timescale 1ns / 1ps

// Allocate runs a first-fit scan, one bitmap word per cycle from the memory read port, then
// marks each word of the run; free checks the pool and the range, then clears each word of
// the run; bad requests are refused at accept or in a check state. Requests are taken one at
// a time; busy_o is high from accept until done_o pulses, and low for an allocate refused at accept.
// Reset: after rst_ni rises a clearing pass writes 2 * 2^max(1, ceil(log2(words))) memory rows
// (256 rows at 4096 pages) with busy_o high. done_o is a one-cycle strobe; no backpressure.
module bitmap_page_run_allocator #(
  parameter int unsigned POOL_PAGES = 4096,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpra_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                func_i,
  input  logic                                pool_select_i,
  input  logic [bpra_pkg::COUNT_W-1:0]        page_count_i,
  input  logic [bpra_pkg::ADDR_W-1:0]         address_i,
  output logic                                done_o,
  output logic [bpra_pkg::STATUS_W-1:0]       status_o,
  output logic [bpra_pkg::ADDR_W-1:0]         run_address_o
);

  localparam int unsigned WB        = bpra_pkg::WORD_BITS;
  localparam int unsigned LW        = bpra_pkg::LANE_W;
  localparam int unsigned NWORDS    = (POOL_PAGES + WB - 1) / WB;
  localparam int unsigned WAW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned PIW       = WAW + LW;
  localparam int unsigned CW        = PIW + 1;
  localparam int unsigned MAW       = WAW + 1;
  localparam int unsigned MEM_DEPTH = 2 ** MAW;
  localparam logic [WAW:0]   NWORDS_V  = (WAW + 1)'(NWORDS);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NWORDS - 1);

  // Configuration registers.
  logic [bpra_pkg::ADDR_W-1:0]  pool0_base_q, pool1_base_q;
  logic [bpra_pkg::PAGES_W-1:0] pool0_pages_q, pool1_pages_q;

  // Controller state.
  bpra_pkg::state_e state_q, state_d;
  logic [MAW-1:0]   clr_q, clr_d;
  logic [WAW:0]     iss_q, iss_d;
  logic             pv_q, pv_d;
  logic [WAW-1:0]   pw_q, pw_d;
  logic             done_q, done_d;

  // Request and working registers.
  logic                          func_q, func_d;
  logic                          pool_q, pool_d;
  logic [bpra_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [bpra_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [CW-1:0]                 eff_q, eff_d;
  logic [CW-1:0]                 carry_q, carry_d;
  logic [PIW-1:0]                lo_q, lo_d, hi_q, hi_d;
  logic [bpra_pkg::ADDR_W-1:0]   res_q, res_d;
  logic [bpra_pkg::STATUS_W-1:0] status_q, status_d;
  logic [bpra_pkg::ADDR_W-1:0]   runaddr_q, runaddr_d;

  // Bitmap memory, one row per 32 pages, pool in the top address bit.
  logic [WB-1:0]  mem [0:MEM_DEPTH-1];
  logic [WB-1:0]  rd_data_q;
  logic           mem_we, mem_re;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [WB-1:0]  mem_wdata;

  // Word evaluation signals.
  logic [bpra_pkg::RUN_W-1:0] run_len [0:LW][0:WB-1];
  logic [CW-1:0]              lane_total [0:WB-1];
  logic [WB-1:0]              lane_free, lane_hit, apply_mask;
  logic [LW-1:0]              hit_lane;
  logic [PIW-1:0]             end_idx, start_idx;

  // Free request checks.
  logic [bpra_pkg::ADDR_W:0]   diff0, diff1;
  logic                        free_pool, free_bad;
  logic [bpra_pkg::ADDR_W-1:0] free_off, free_idx, free_end;
  logic                        range_bad;

  // Pool size clipped to the bitmap capacity.
  function automatic logic [CW-1:0] eff_of(logic [bpra_pkg::PAGES_W-1:0] pages);
    if (32'(pages) > POOL_PAGES) begin
      return CW'(POOL_PAGES);
    end
    return CW'(pages);
  endfunction

  assign busy_o        = (state_q != bpra_pkg::S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign run_address_o = runaddr_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool0_base_q  <= 32'h0020_0000;
      pool1_base_q  <= 32'h0120_0000;
      pool0_pages_q <= 13'd4096;
      pool1_pages_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpra_pkg::CFG_POOL0_BASE:  pool0_base_q  <= cfg_wdata_i;
        bpra_pkg::CFG_POOL1_BASE:  pool1_base_q  <= cfg_wdata_i;
        bpra_pkg::CFG_POOL0_PAGES: pool0_pages_q <= cfg_wdata_i[bpra_pkg::PAGES_W-1:0];
        bpra_pkg::CFG_POOL1_PAGES: pool1_pages_q <= cfg_wdata_i[bpra_pkg::PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // Free-run length ending at each lane, built by doubling over the word.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      lane_free[j] = !rd_data_q[j] && (CW'({pw_q, LW'(j)}) < eff_q);
      run_len[0][j] = bpra_pkg::RUN_W'(lane_free[j]);
    end
    for (int k = 0; k < LW; k++) begin
      for (int j = 0; j < WB; j++) begin
        run_len[k+1][j] = run_len[k][j];
        if ((j >= (1 << k)) && (run_len[k][j] == bpra_pkg::RUN_W'(1 << k))) begin
          run_len[k+1][j] = run_len[k][j] + run_len[k][(j >= (1 << k)) ? j - (1 << k) : 0];
        end
      end
    end
    for (int j = 0; j < WB; j++) begin
      if (run_len[LW][j] == bpra_pkg::RUN_W'(j + 1)) begin
        lane_total[j] = CW'(j + 1) + carry_q;
      end else begin
        lane_total[j] = CW'(run_len[LW][j]);
      end
      lane_hit[j] = (32'(lane_total[j]) >= 32'(count_q));
    end
    hit_lane = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        hit_lane = LW'(j);
      end
    end
    end_idx   = {pw_q, hit_lane};
    start_idx = PIW'(32'(end_idx) + 32'd1 - 32'(count_q));
  end

  // Lanes of the current word that fall inside the run being marked or freed.
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      apply_mask[j] = ({pw_q, LW'(j)} >= lo_q) && ({pw_q, LW'(j)} <= hi_q);
    end
  end

  // Free request: pool choice and offset, then range check against the pool size.
  always_comb begin
    diff0     = {1'b0, addr_q} - {1'b0, pool0_base_q};
    diff1     = {1'b0, addr_q} - {1'b0, pool1_base_q};
    free_pool = !diff1[bpra_pkg::ADDR_W];
    free_bad  = (count_q == '0) || (!free_pool && diff0[bpra_pkg::ADDR_W]);
    free_off  = free_pool ? diff1[bpra_pkg::ADDR_W-1:0] : diff0[bpra_pkg::ADDR_W-1:0];
    free_idx  = addr_q >> PAGE_SHIFT;
    free_end  = free_idx + 32'(count_q);
    range_bad = (free_end > 32'(eff_q));
  end

  // Next-state and memory control.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    iss_d     = iss_q;
    pv_d      = 1'b0;
    pw_d      = pw_q;
    done_d    = 1'b0;
    func_d    = func_q;
    pool_d    = pool_q;
    count_d   = count_q;
    addr_d    = addr_q;
    eff_d     = eff_q;
    carry_d   = carry_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    res_d     = res_q;
    status_d  = status_q;
    runaddr_d = runaddr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {pool_q, pw_q};
    mem_raddr = {pool_q, iss_q[WAW-1:0]};
    if (func_q == bpra_pkg::FUNC_ALLOC) begin
      mem_wdata = rd_data_q | apply_mask;
    end else begin
      mem_wdata = rd_data_q & ~apply_mask;
    end

    case (state_q)
      bpra_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = bpra_pkg::S_IDLE;
        end
      end

      bpra_pkg::S_IDLE: begin
        if (start_i) begin
          func_d  = func_i;
          pool_d  = pool_select_i;
          count_d = page_count_i;
          addr_d  = address_i;
          if (func_i == bpra_pkg::FUNC_FREE) begin
            state_d = bpra_pkg::S_FCHK;
          end else if ((page_count_i == '0) || (32'(page_count_i) > POOL_PAGES)) begin
            done_d    = 1'b1;
            status_d  = bpra_pkg::ST_BAD;
            runaddr_d = '0;
          end else begin
            eff_d   = eff_of(pool_select_i ? pool1_pages_q : pool0_pages_q);
            iss_d   = '0;
            carry_d = '0;
            state_d = bpra_pkg::S_SCAN;
          end
        end
      end

      bpra_pkg::S_FCHK: begin
        if (free_bad) begin
          done_d    = 1'b1;
          status_d  = bpra_pkg::ST_BAD;
          runaddr_d = '0;
          state_d   = bpra_pkg::S_IDLE;
        end else begin
          pool_d  = free_pool;
          addr_d  = free_off;
          eff_d   = eff_of(free_pool ? pool1_pages_q : pool0_pages_q);
          state_d = bpra_pkg::S_FRNG;
        end
      end

      bpra_pkg::S_FRNG: begin
        if (range_bad) begin
          done_d    = 1'b1;
          status_d  = bpra_pkg::ST_BAD;
          runaddr_d = '0;
          state_d   = bpra_pkg::S_IDLE;
        end else begin
          lo_d    = PIW'(free_idx);
          hi_d    = PIW'(free_end - 32'd1);
          iss_d   = {1'b0, free_idx[PIW-1:LW]};
          state_d = bpra_pkg::S_APPLY;
        end
      end

      bpra_pkg::S_SCAN: begin
        // Issue one word read per cycle and evaluate the word read in the cycle before.
        if (iss_q < NWORDS_V) begin
          mem_re = 1'b1;
          pv_d   = 1'b1;
          pw_d   = iss_q[WAW-1:0];
          iss_d  = iss_q + 1'b1;
        end
        if (pv_q) begin
          carry_d = lane_total[WB-1];
          if (|lane_hit) begin
            lo_d    = start_idx;
            hi_d    = end_idx;
            iss_d   = {1'b0, start_idx[PIW-1:LW]};
            pv_d    = 1'b0;
            state_d = bpra_pkg::S_APPLY;
          end else if (pw_q == LAST_WORD) begin
            done_d    = 1'b1;
            status_d  = bpra_pkg::ST_NOSPACE;
            runaddr_d = '0;
            pv_d      = 1'b0;
            state_d   = bpra_pkg::S_IDLE;
          end
        end
      end

      bpra_pkg::S_APPLY: begin
        res_d = (pool_q ? pool1_base_q : pool0_base_q) + (32'(lo_q) << PAGE_SHIFT);
        // Read each covered word, write it back modified on the next cycle.
        if (iss_q <= {1'b0, hi_q[PIW-1:LW]}) begin
          mem_re = 1'b1;
          pv_d   = 1'b1;
          pw_d   = iss_q[WAW-1:0];
          iss_d  = iss_q + 1'b1;
        end
        if (pv_q) begin
          mem_we = 1'b1;
          if (pw_q == hi_q[PIW-1:LW]) begin
            done_d    = 1'b1;
            status_d  = bpra_pkg::ST_DONE;
            runaddr_d = (func_q == bpra_pkg::FUNC_ALLOC) ? res_q : '0;
            pv_d      = 1'b0;
            state_d   = bpra_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = bpra_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpra_pkg::S_CLEAR;
      clr_q   <= '0;
      iss_q   <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      iss_q   <= iss_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    pw_q      <= pw_d;
    func_q    <= func_d;
    pool_q    <= pool_d;
    count_q   <= count_d;
    addr_q    <= addr_d;
    eff_q     <= eff_d;
    carry_q   <= carry_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_q     <= res_d;
    status_q  <= status_d;
    runaddr_q <= runaddr_d;
  end

  // Bitmap memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Read and write of the same row never fall in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("bitmap row read and written in the same cycle");

  // The memory is written only by the clearing pass and the mark/free pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == bpra_pkg::S_CLEAR) || (state_q == bpra_pkg::S_APPLY)))
    else $error("bitmap written outside clear or apply");

  // A result carries one of the defined status codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == bpra_pkg::ST_DONE) || (status_o == bpra_pkg::ST_NOSPACE) ||
                (status_o == bpra_pkg::ST_BAD)))
    else $error("undefined status code");

  // Refused requests report a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != bpra_pkg::ST_DONE)) |-> (run_address_o == '0))
    else $error("nonzero address on refused request");

  // A word is evaluated in the scan only after its read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pv_q && (state_q == bpra_pkg::S_SCAN)) |-> $past(mem_re))
    else $error("scan evaluated a word that was not read");

endmodule
